@@ sv/fcwd_pkg.sv @@
package fcwd_pkg;

	localparam int MAX_TAPS_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam int CMD_W         = 2;
	localparam int TAP_INDEX_W   = 10;
	localparam int TAP_COUNT_W   = 11;
	localparam int GAIN_W        = 16;
	localparam int MIX_W         = 17;
	localparam int CFG_DATA_W    = 17;
	localparam int CFG_INDEX_W   = 2;
	localparam int GAIN_FRAC     = 12;
	localparam int MIX_FRAC      = 16;
	localparam int OP_W          = 2;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TAP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IR_GAIN   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX   = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
	localparam logic [MIX_W-1:0]  MIX_ONE    = 17'h10000;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE,
		OP_PASS,
		OP_TAP,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_GAIN,
		ST_MIX,
		ST_OUT
	} bst_t;

	typedef struct packed {
		logic [TAP_COUNT_W-1:0] tap_count;
		logic [GAIN_W-1:0]      ir_gain;
		logic [MIX_W-1:0]       wet_mix;
	} cfg_t;

	typedef struct packed {
		logic pop;
		op_t  op;
		logic load;
		bst_t st;
	} bstat_t;

endpackage

@@ sv/fcwd_in_if.sv @@
interface fcwd_in_if #(
	parameter int SAMPLE_BITS = fcwd_pkg::SAMPLE_BITS_DEF
) ();
	import fcwd_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [CMD_W-1:0]              cmd;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [TAP_INDEX_W-1:0]        tap_index;
	logic signed [SAMPLE_BITS-1:0] tap_value;

	modport source (output valid, cmd, sample_in, tap_index, tap_value, input ready);
	modport sink (input valid, cmd, sample_in, tap_index, tap_value, output ready);

endinterface

@@ sv/fcwd_out_if.sv @@
interface fcwd_out_if #(
	parameter int SAMPLE_BITS = fcwd_pkg::SAMPLE_BITS_DEF
) ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);

endinterface

@@ sv/fir_convolver_wet_dry.sv @@
// Audio sample with N taps in use: the back end works through the taps one tap per cycle
// through a single multiply-accumulate fed by the history and coefficient RAM read ports.
// It then drains, applies the IR gain, mixes wet and dry and registers the result.
// Pass-through goes straight to the result register; tap write and history clear beats give no result.
// Reset (arst_n low) clears control state and resets config; history reads as zero through a
// fill count, so there is no clearing pass. Coefficients are undefined until written.
module fir_convolver_wet_dry #(
	parameter int MAX_TAPS    = fcwd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fcwd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fcwd_in_if.sink                             item,
	fcwd_out_if.source                          result,
	input  logic                                cfg_we,
	input  logic [fcwd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fcwd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fcwd_pkg::*;

	localparam int AW = $clog2(MAX_TAPS);
	localparam int QW = OP_W + SAMPLE_BITS + AW;

	cfg_t          cfg_q;
	logic          push;
	logic [QW-1:0] push_data;
	logic          q_full;
	logic          q_valid;
	logic [QW-1:0] q_data;
	bstat_t        bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_count <= '0;
			cfg_q.ir_gain   <= GAIN_RESET;
			cfg_q.wet_mix   <= MIX_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAP_COUNT: cfg_q.tap_count <= cfg_data[TAP_COUNT_W-1:0];
				REG_IR_GAIN:   cfg_q.ir_gain   <= cfg_data[GAIN_W-1:0];
				REG_WET_MIX:   cfg_q.wet_mix   <= cfg_data[MIX_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	fcwd_front #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.item      (item),
		.tap_count (cfg_q.tap_count),
		.full      (q_full),
		.push      (push),
		.push_data (push_data)
	);

	fcwd_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (bstat.pop),
		.pop_data  (q_data),
		.valid     (q_valid)
	);

	fcwd_back #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_data),
		.stat    (bstat),
		.result  (result)
	);

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> q_valid)
		else $error("queue read while empty");

	a_ctrl_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop && (bstat.op == OP_TAP || bstat.op == OP_CLEAR) |=> bstat.st == ST_IDLE)
		else $error("tap or clear beat held the back end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.load |-> (!result.valid || result.ready))
		else $error("result register overwritten");
`endif

endmodule

@@ sv/fcwd_ram.sv @@
module fcwd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/fcwd_fifo.sv @@
module fcwd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = fcwd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);

	localparam int PW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;

	assign full     = (cnt_q == CNTW'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + CNTW'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - CNTW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

@@ sv/fcwd_front.sv @@
module fcwd_front #(
	parameter int MAX_TAPS    = fcwd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fcwd_pkg::SAMPLE_BITS_DEF
) (
	fcwd_in_if.sink                                   item,
	input  logic [fcwd_pkg::TAP_COUNT_W-1:0]          tap_count,
	input  logic                                      full,
	output logic                                      push,
	output logic [fcwd_pkg::OP_W+SAMPLE_BITS+$clog2(MAX_TAPS)-1:0] push_data
);
	import fcwd_pkg::*;

	localparam int AW = $clog2(MAX_TAPS);

	op_t                    op;
	logic                   keep;
	logic [SAMPLE_BITS-1:0] word;

	always_comb begin
		op   = OP_SAMPLE;
		keep = 1'b0;
		word = item.sample_in;
		case (item.cmd)
			CMD_SAMPLE: begin
				keep = 1'b1;
				op   = (tap_count == '0) ? OP_PASS : OP_SAMPLE;
			end
			CMD_TAP: begin
				keep = (32'(item.tap_index) < 32'(MAX_TAPS));
				op   = OP_TAP;
				word = item.tap_value;
			end
			CMD_CLEAR: begin
				keep = 1'b1;
				op   = OP_CLEAR;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item.ready = !full;
	assign push       = item.valid && !full && keep;
	assign push_data  = {op, word, AW'(item.tap_index)};

endmodule

@@ sv/fcwd_back.sv @@
module fcwd_back #(
	parameter int MAX_TAPS    = fcwd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fcwd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  fcwd_pkg::cfg_t                                        cfg,
	input  logic                                                  q_valid,
	input  logic [fcwd_pkg::OP_W+SAMPLE_BITS+$clog2(MAX_TAPS)-1:0] q_data,
	output fcwd_pkg::bstat_t                                      stat,
	fcwd_out_if.source                                            result
);
	import fcwd_pkg::*;

	localparam int AW    = $clog2(MAX_TAPS);
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int TW    = (CW > TAP_COUNT_W) ? CW : TAP_COUNT_W;
	localparam int SB    = SAMPLE_BITS;
	localparam int F     = SAMPLE_BITS - 1;
	localparam int PW    = 2 * SAMPLE_BITS;
	localparam int ACC_W = PW + AW;
	localparam int S1W   = ACC_W - F;
	localparam int GW    = S1W + GAIN_W + 1;
	localparam int WW    = SAMPLE_BITS + 18;
	localparam int DW    = SAMPLE_BITS + MIX_W + 1;
	localparam int XW    = WW + MIX_W + 1;
	localparam int MW    = XW + 1;

	localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(1) << (F - 1);
	localparam logic signed [GW-1:0]    GAIN_HALF = GW'(1) << (GAIN_FRAC - 1);
	localparam logic signed [MW-1:0]    MIX_HALF  = MW'(1) << (MIX_FRAC - 1);
	localparam logic signed [WW-1:0]    WMAX      = {1'b0, {(WW - 1){1'b1}}};
	localparam logic signed [WW-1:0]    WMIN      = {1'b1, {(WW - 1){1'b0}}};
	localparam logic signed [SB-1:0]    SMAX      = {1'b0, {(SB - 1){1'b1}}};
	localparam logic signed [SB-1:0]    SMIN      = {1'b1, {(SB - 1){1'b0}}};

	// queue head
	op_t                   h_op;
	logic signed [SB-1:0]  h_smp;
	logic [AW-1:0]         h_addr;

	bst_t                  st_q;
	bst_t                  st_d;
	logic                  pop;
	logic                  hist_we;
	logic                  coef_we;
	logic                  issue;
	logic                  load;

	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         rp_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         taps_q;
	logic [TW-1:0]         tc_ext;
	logic signed [SB-1:0]  dry_q;
	logic                  pass_q;

	logic [SB-1:0]         h_rdata;
	logic [SB-1:0]         c_rdata;
	logic                  v_s1;
	logic                  live_s1;
	logic                  v_s2;
	logic signed [PW-1:0]  prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [ACC_W-1:0] acc_sh;
	logic signed [S1W-1:0]   s1;
	logic signed [GW-1:0]    gmul_q;
	logic signed [GW-1:0]    wet_sh;
	logic signed [WW-1:0]    wet_c;
	logic [MIX_W-1:0]        m_eff;
	logic [MIX_W-1:0]        dry_w;
	logic signed [DW-1:0]    dmul_q;
	logic signed [XW-1:0]    wmul_q;
	logic signed [MW-1:0]    mix_sh;
	logic signed [SB-1:0]    sat;
	logic signed [SB-1:0]    out_d_q;
	logic                    out_v_q;

	assign h_op   = op_t'(q_data[AW+SB +: OP_W]);
	assign h_smp  = q_data[AW +: SB];
	assign h_addr = q_data[AW-1:0];

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (h_op)
						OP_SAMPLE: st_d = ST_MAC;
						OP_PASS:   st_d = ST_OUT;
						default:   st_d = ST_IDLE;
					endcase
				end
			end
			ST_MAC: begin
				if (k_q == taps_q - CW'(1)) begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					st_d = ST_GAIN;
				end
			end
			ST_GAIN: st_d = ST_MIX;
			ST_MIX:  st_d = ST_OUT;
			ST_OUT: begin
				if (!out_v_q || result.ready) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = (st_q == ST_IDLE) && q_valid;
		hist_we = pop && (h_op == OP_SAMPLE);
		coef_we = pop && (h_op == OP_TAP);
		issue   = (st_q == ST_MAC);
		load    = (st_q == ST_OUT) && (!out_v_q || result.ready);
	end

	assign stat = '{pop: pop, op: h_op, load: load, st: st_q};

	fcwd_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_q),
		.wdata (h_smp),
		.raddr (rp_q),
		.rdata (h_rdata)
	);

	fcwd_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (h_addr),
		.wdata (h_smp),
		.raddr (k_q[AW-1:0]),
		.rdata (c_rdata)
	);

	assign tc_ext = TW'(cfg.tap_count);

	// post-processing arithmetic
	always_comb begin
		acc_sh = (acc_q + ACC_HALF) >>> F;
		s1     = S1W'(acc_sh);
		wet_sh = (gmul_q + GAIN_HALF) >>> GAIN_FRAC;
		if (wet_sh > WMAX) begin
			wet_c = WMAX;
		end else if (wet_sh < WMIN) begin
			wet_c = WMIN;
		end else begin
			wet_c = WW'(wet_sh);
		end
		m_eff  = (cfg.wet_mix > MIX_ONE) ? MIX_ONE : cfg.wet_mix;
		dry_w  = MIX_ONE - m_eff;
		mix_sh = (MW'(dmul_q) + MW'(wmul_q) + MIX_HALF) >>> MIX_FRAC;
		if (mix_sh > SMAX) begin
			sat = SMAX;
		end else if (mix_sh < SMIN) begin
			sat = SMIN;
		end else begin
			sat = SB'(mix_sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			wp_q    <= '0;
			fill_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (pop && (h_op == OP_CLEAR)) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else if (hist_we) begin
				wp_q <= (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
				if (fill_q != CW'(MAX_TAPS)) begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dry_q  <= h_smp;
			pass_q <= (h_op == OP_PASS);
			rp_q   <= wp_q;
			k_q    <= '0;
			acc_q  <= '0;
			taps_q <= (tc_ext > TW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tc_ext);
		end
		if (issue) begin
			rp_q <= (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - AW'(1);
			k_q  <= k_q + CW'(1);
		end
		live_s1 <= (k_q < fill_q);
		if (live_s1) begin
			prod_s2 <= $signed(h_rdata) * $signed(c_rdata);
		end else begin
			prod_s2 <= '0;
		end
		if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (st_q == ST_GAIN) begin
			gmul_q <= s1 * $signed({1'b0, cfg.ir_gain});
		end
		if (st_q == ST_MIX) begin
			dmul_q <= dry_q * $signed({1'b0, dry_w});
			wmul_q <= wet_c * $signed({1'b0, m_eff});
		end
		if (load) begin
			out_d_q <= pass_q ? dry_q : sat;
		end
	end

	assign result.valid      = out_v_q;
	assign result.sample_out = out_d_q;

endmodule
